[sv/dqbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbd_pkg
// Shared types, constants and the sigmoid lookup for the query box decoder.
// ----------------------------------------------------------------------------
package dqbd_pkg;

    localparam int CLASS_COUNT = 7;
    localparam int PAIR_COUNT  = (CLASS_COUNT + 1) / 2;
    localparam int CLS_IDX_W   = 3;

    localparam int COORD_W  = 16;
    localparam int SCALE_W  = 13;
    localparam int PROD_W   = COORD_W + SCALE_W;
    localparam int POS_W    = 18;
    localparam int EXT_W    = 17;
    localparam int CONF_W   = 16;
    localparam int FRAC_W   = 10;
    localparam int SEG_W    = 5;
    localparam int DIFF_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NET_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NET_HEIGHT = 2'd1;
    localparam logic [SCALE_W-1:0]   NET_SIZE_RESET = 13'd640;

    typedef logic        [COORD_W-1:0]   coord_t;
    typedef logic signed [15:0]          logit_t;
    typedef logic        [SCALE_W-1:0]   scale_t;
    typedef logic signed [POS_W-1:0]     pos_t;
    typedef logic        [EXT_W-1:0]     ext_t;
    typedef logic        [CLS_IDX_W-1:0] cls_idx_t;
    typedef logic        [CONF_W-1:0]    conf_t;

    typedef struct packed {
        coord_t centre_x;
        coord_t centre_y;
        coord_t norm_width;
        coord_t norm_height;
        logit_t [CLASS_COUNT-1:0] logit;
    } item_t;

    // sigmoid(k/4) in Q0.16, k = 0 .. 32
    function automatic conf_t sig_lut(input logic [SEG_W:0] k);
        conf_t v;
        case (k)
            6'd0:  v = 16'd32768;
            6'd1:  v = 16'd36842;
            6'd2:  v = 16'd40793;
            6'd3:  v = 16'd44511;
            6'd4:  v = 16'd47911;
            6'd5:  v = 16'd50941;
            6'd6:  v = 16'd53581;
            6'd7:  v = 16'd55834;
            6'd8:  v = 16'd57724;
            6'd9:  v = 16'd59287;
            6'd10: v = 16'd60565;
            6'd11: v = 16'd61598;
            6'd12: v = 16'd62428;
            6'd13: v = 16'd63090;
            6'd14: v = 16'd63615;
            6'd15: v = 16'd64030;
            6'd16: v = 16'd64357;
            6'd17: v = 16'd64614;
            6'd18: v = 16'd64816;
            6'd19: v = 16'd64974;
            6'd20: v = 16'd65097;
            6'd21: v = 16'd65194;
            6'd22: v = 16'd65269;
            6'd23: v = 16'd65328;
            6'd24: v = 16'd65374;
            6'd25: v = 16'd65410;
            6'd26: v = 16'd65438;
            6'd27: v = 16'd65459;
            6'd28: v = 16'd65476;
            6'd29: v = 16'd65489;
            6'd30: v = 16'd65500;
            6'd31: v = 16'd65508;
            6'd32: v = 16'd65514;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

[sv/detection_query_box_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_query_box_decoder
// Picks the winning class of a detector query, drops it when that logit is
// negative, else gives the pixel box, class index and sigmoid confidence.
//
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    centre_x/y, norm_width/height, logit_0..6
//   m_       out  m_valid / m_ready    box_left/top, box_width/height_px,
//                                      class_index, confidence
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; four
// register stages (multiply, round, table, interpolate) lie between an
// accepted input beat and the output beat of a kept query.
// Dropped queries leave a bubble and produce no output beat.
// Reset restores net_width and net_height to 640 and empties the pipeline.
// A stalled output holds the whole pipeline; a one-beat input skid buffer
// keeps s_ready registered. cfg_ready is always high.
// ----------------------------------------------------------------------------
module detection_query_box_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  dqbd_pkg::coord_t              s_centre_x,
    input  dqbd_pkg::coord_t              s_centre_y,
    input  dqbd_pkg::coord_t              s_norm_width,
    input  dqbd_pkg::coord_t              s_norm_height,
    input  dqbd_pkg::logit_t              s_logit_0,
    input  dqbd_pkg::logit_t              s_logit_1,
    input  dqbd_pkg::logit_t              s_logit_2,
    input  dqbd_pkg::logit_t              s_logit_3,
    input  dqbd_pkg::logit_t              s_logit_4,
    input  dqbd_pkg::logit_t              s_logit_5,
    input  dqbd_pkg::logit_t              s_logit_6,

    output logic                          m_valid,
    input  logic                          m_ready,
    output dqbd_pkg::pos_t                m_box_left,
    output dqbd_pkg::pos_t                m_box_top,
    output dqbd_pkg::ext_t                m_box_width_px,
    output dqbd_pkg::ext_t                m_box_height_px,
    output dqbd_pkg::cls_idx_t            m_class_index,
    output dqbd_pkg::conf_t               m_confidence,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dqbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  dqbd_pkg::scale_t              cfg_data
);
    import dqbd_pkg::*;

    scale_t net_width_reg;
    scale_t net_height_reg;

    item_t port_item;
    item_t skid_reg;
    logic  skid_full_reg;
    logic  skid_full_next;
    item_t cur_item;
    logic  cur_valid;
    logic  adv;

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;

    pos_t     lane_x_pos, lane_y_pos;
    ext_t     lane_x_ext, lane_y_ext;
    logit_t   best_val;
    cls_idx_t best_idx;
    conf_t    conf;

    pos_t     left3_reg, top3_reg;
    ext_t     wid3_reg, hgt3_reg;
    cls_idx_t idx3_reg;
    pos_t     left_reg, top_reg;
    ext_t     wid_reg, hgt_reg;
    cls_idx_t idx_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_width_reg  <= NET_SIZE_RESET;
            net_height_reg <= NET_SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NET_WIDTH:  net_width_reg  <= cfg_data;
                REG_NET_HEIGHT: net_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input skid
    assign port_item = '{centre_x:    s_centre_x,
                         centre_y:    s_centre_y,
                         norm_width:  s_norm_width,
                         norm_height: s_norm_height,
                         logit:       {s_logit_6, s_logit_5, s_logit_4, s_logit_3,
                                       s_logit_2, s_logit_1, s_logit_0}};

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !skid_full_reg;
    assign cur_item  = skid_full_reg ? skid_reg : port_item;
    assign cur_valid = skid_full_reg || s_valid;

    always_comb begin
        skid_full_next = skid_full_reg;
        if (adv) begin
            skid_full_next = 1'b0;
        end else if (s_valid && s_ready) begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && s_ready) begin
            skid_reg <= port_item;
        end
    end

    // lanes and merge tree
    dqbd_box_lane u_lane_x (
        .aclk   (aclk),
        .adv    (adv),
        .centre (cur_item.centre_x),
        .extent (cur_item.norm_width),
        .scale  (net_width_reg),
        .pos_q4 (lane_x_pos),
        .ext_q4 (lane_x_ext)
    );

    dqbd_box_lane u_lane_y (
        .aclk   (aclk),
        .adv    (adv),
        .centre (cur_item.centre_y),
        .extent (cur_item.norm_height),
        .scale  (net_height_reg),
        .pos_q4 (lane_y_pos),
        .ext_q4 (lane_y_ext)
    );

    dqbd_argmax u_argmax (
        .aclk     (aclk),
        .adv      (adv),
        .logit    (cur_item.logit),
        .best_val (best_val),
        .best_idx (best_idx)
    );

    dqbd_sigmoid u_sigmoid (
        .aclk (aclk),
        .adv  (adv),
        .x    (best_val),
        .conf (conf)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
            if (adv) begin
                v1_reg      <= cur_valid;
                v2_reg      <= v1_reg;
                // negative winner: query dropped here
                v3_reg      <= v2_reg && !best_val[15];
                m_valid_reg <= v3_reg;
            end
        end
    end

    // box and class alignment with the sigmoid stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            left3_reg <= lane_x_pos;
            top3_reg  <= lane_y_pos;
            wid3_reg  <= lane_x_ext;
            hgt3_reg  <= lane_y_ext;
            idx3_reg  <= best_idx;
            left_reg  <= left3_reg;
            top_reg   <= top3_reg;
            wid_reg   <= wid3_reg;
            hgt_reg   <= hgt3_reg;
            idx_reg   <= idx3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_box_left      = left_reg;
    assign m_box_top       = top_reg;
    assign m_box_width_px  = wid_reg;
    assign m_box_height_px = hgt_reg;
    assign m_class_index   = idx_reg;
    assign m_confidence    = conf;

endmodule

[sv/dqbd_box_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbd_box_lane
// One axis of the box: scales centre and size by the network size and
// gives the leading edge and extent in pixels with 4 fraction bits.
// ----------------------------------------------------------------------------
module dqbd_box_lane (
    input  logic            aclk,
    input  logic            adv,
    input  dqbd_pkg::coord_t centre,
    input  dqbd_pkg::coord_t extent,
    input  dqbd_pkg::scale_t scale,
    output dqbd_pkg::pos_t  pos_q4,
    output dqbd_pkg::ext_t  ext_q4
);
    import dqbd_pkg::*;

    logic [PROD_W-1:0] cs_reg;
    logic [PROD_W-1:0] ds_reg;
    logic signed [31:0] num;
    logic signed [31:0] num_rnd;
    logic signed [18:0] quot;
    logic [PROD_W:0]    ds_rnd;
    logic [PROD_W-12:0] ext_full;
    pos_t pos_reg;
    pos_t pos_next;
    ext_t ext_reg;
    ext_t ext_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cs_reg  <= PROD_W'(centre) * PROD_W'(scale);
            ds_reg  <= PROD_W'(extent) * PROD_W'(scale);
            pos_reg <= pos_next;
            ext_reg <= ext_next;
        end
    end

    always_comb begin
        // 2*c*S - d*S, rounded half up at bit 13
        num     = $signed({2'b00, cs_reg, 1'b0}) - $signed({3'b000, ds_reg});
        num_rnd = num + 32'sd4096;
        quot    = num_rnd[31:13];
        if (quot > 19'sd131071) begin
            pos_next = {1'b0, {(POS_W-1){1'b1}}};
        end else if (quot < -19'sd131072) begin
            pos_next = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pos_next = quot[POS_W-1:0];
        end

        ds_rnd   = {1'b0, ds_reg} + (PROD_W+1)'(2048);
        ext_full = ds_rnd[PROD_W:12];
        if (ext_full[PROD_W-12:EXT_W] != '0) begin
            ext_next = {EXT_W{1'b1}};
        end else begin
            ext_next = ext_full[EXT_W-1:0];
        end
    end

    assign pos_q4 = pos_reg;
    assign ext_q4 = ext_reg;

endmodule

[sv/dqbd_argmax.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbd_argmax
// Two-level registered compare tree over the class logits; the lower index
// wins a tie at every node.
// ----------------------------------------------------------------------------
module dqbd_argmax (
    input  logic                                       aclk,
    input  logic                                       adv,
    input  dqbd_pkg::logit_t [dqbd_pkg::CLASS_COUNT-1:0] logit,
    output dqbd_pkg::logit_t                           best_val,
    output dqbd_pkg::cls_idx_t                         best_idx
);
    import dqbd_pkg::*;

    logit_t   [PAIR_COUNT-1:0] pv_reg;
    logit_t   [PAIR_COUNT-1:0] pv_next;
    cls_idx_t [PAIR_COUNT-1:0] pi_reg;
    cls_idx_t [PAIR_COUNT-1:0] pi_next;
    logit_t   val_reg;
    logit_t   val_next;
    cls_idx_t idx_reg;
    cls_idx_t idx_next;

    always_comb begin
        for (int p = 0; p < PAIR_COUNT; p++) begin
            pv_next[p] = logit[2*p];
            pi_next[p] = CLS_IDX_W'(2*p);
            if (2*p + 1 < CLASS_COUNT) begin
                if (logit[2*p+1] > logit[2*p]) begin
                    pv_next[p] = logit[2*p+1];
                    pi_next[p] = CLS_IDX_W'(2*p + 1);
                end
            end
        end
    end

    // candidates are in index order, so strict greater keeps the first
    always_comb begin
        val_next = pv_reg[0];
        idx_next = pi_reg[0];
        for (int p = 1; p < PAIR_COUNT; p++) begin
            if (pv_reg[p] > val_next) begin
                val_next = pv_reg[p];
                idx_next = pi_reg[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pv_reg  <= pv_next;
            pi_reg  <= pi_next;
            val_reg <= val_next;
            idx_reg <= idx_next;
        end
    end

    assign best_val = val_reg;
    assign best_idx = idx_reg;

endmodule

[sv/dqbd_sigmoid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqbd_sigmoid
// Sigmoid of a non-negative Q4.12 logit: table segment of 1/4 then
// linear interpolation over the low 10 bits. Two register stages.
// ----------------------------------------------------------------------------
module dqbd_sigmoid (
    input  logic              aclk,
    input  logic              adv,
    input  dqbd_pkg::logit_t  x,
    output dqbd_pkg::conf_t   conf
);
    import dqbd_pkg::*;

    logic [SEG_W-1:0]  seg;
    conf_t             lo_tab;
    conf_t             hi_tab;
    conf_t             diff_full;
    conf_t             lo_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [DIFF_W+FRAC_W-1:0] prod;
    logic [DIFF_W+FRAC_W-1:0] prod_rnd;
    conf_t             conf_reg;
    conf_t             conf_next;

    always_comb begin
        seg       = x[14:FRAC_W];
        lo_tab    = sig_lut({1'b0, seg});
        hi_tab    = sig_lut({1'b0, seg} + (SEG_W+1)'(1));
        diff_full = hi_tab - lo_tab;
        prod      = (DIFF_W+FRAC_W)'(diff_reg) * (DIFF_W+FRAC_W)'(frac_reg);
        prod_rnd  = prod + (DIFF_W+FRAC_W)'(512);
        conf_next = lo_reg + CONF_W'(prod_rnd[DIFF_W+FRAC_W-1:FRAC_W]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg   <= lo_tab;
            diff_reg <= diff_full[DIFF_W-1:0];
            frac_reg <= x[FRAC_W-1:0];
            conf_reg <= conf_next;
        end
    end

    assign conf = conf_reg;

endmodule
